// ===== src/psd_pkg.sv =====
`default_nettype none
package psd_pkg;
	localparam int DIST_BITS = 25;
	localparam int PART_BITS = 2;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 3;

	localparam logic [PART_BITS-1:0] PART_INTERIOR = 2'd0;
	localparam logic [PART_BITS-1:0] PART_START = 2'd1;
	localparam logic [PART_BITS-1:0] PART_END = 2'd2;

	localparam logic [0:0] REG_CLAMP_TO_SEGMENT = 1'b0;

	typedef struct packed {
		logic valid;
		logic [PART_BITS-1:0] part;
	} psd_tag_t;
endpackage
`default_nettype wire

// ===== src/psd_ratio_root.sv =====
`default_nettype none
module psd_ratio_root #(
	parameter int NUMW = 100,
	parameter int DENW = 50
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire psd_pkg::psd_tag_t tag_in,
	input wire logic [NUMW-1:0] num,
	input wire logic [DENW-1:0] den,
	output psd_pkg::psd_tag_t tag_out,
	output logic [psd_pkg::DIST_BITS-1:0] root
);
	localparam int DB = psd_pkg::DIST_BITS;
	localparam int QB = 2 * DB;
	localparam int RW = (NUMW > DENW + QB) ? NUMW : DENW + QB;

	// saturation check, then one quotient bit a stage, then one root bit a stage
	psd_pkg::psd_tag_t tag_d_s [QB+1];
	logic sat_d_s [QB+1];
	logic [RW-1:0] rem_d_s [QB+1];
	logic [DENW-1:0] den_d_s [QB+1];
	logic [QB-1:0] quo_d_s [QB+1];

	psd_pkg::psd_tag_t tag_r_s [DB+1];
	logic sat_r_s [DB+1];
	logic [QB:0] rem_r_s [DB+1];
	logic [DB-1:0] root_r_s [DB+1];

	logic [RW:0] num_ext;
	logic [RW:0] lim_ext;

	assign num_ext = (RW+1)'(num);
	assign lim_ext = (RW+1)'(den) << QB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_d_s[0] <= '0;
		end else begin
			tag_d_s[0] <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		sat_d_s[0] <= (num_ext >= lim_ext);
		rem_d_s[0] <= RW'(num);
		den_d_s[0] <= den;
		quo_d_s[0] <= '0;
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int BIT = QB - 1 - k;
		logic [RW-1:0] trial;
		logic take;

		assign trial = RW'(den_d_s[k]) << BIT;
		assign take = (rem_d_s[k] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_d_s[k+1] <= '0;
			end else begin
				tag_d_s[k+1] <= tag_d_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sat_d_s[k+1] <= sat_d_s[k];
			den_d_s[k+1] <= den_d_s[k];
			rem_d_s[k+1] <= take ? (rem_d_s[k] - trial) : rem_d_s[k];
			quo_d_s[k+1] <= quo_d_s[k] | (QB'(take) << BIT);
		end
	end

	assign tag_r_s[0] = tag_d_s[QB];
	assign sat_r_s[0] = sat_d_s[QB];
	assign rem_r_s[0] = (QB+1)'(quo_d_s[QB]);
	assign root_r_s[0] = '0;

	for (genvar j = 0; j < DB; j++) begin : g_sqrt
		localparam int BIT = DB - 1 - j;
		logic [QB:0] trial;
		logic take;

		assign trial = ((QB+1)'(root_r_s[j]) << (BIT + 1)) | ((QB+1)'(1) << (2 * BIT));
		assign take = (rem_r_s[j] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_r_s[j+1] <= '0;
			end else begin
				tag_r_s[j+1] <= tag_r_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sat_r_s[j+1] <= sat_r_s[j];
			rem_r_s[j+1] <= take ? (rem_r_s[j] - trial) : rem_r_s[j];
			root_r_s[j+1] <= root_r_s[j] | (DB'(take) << BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else begin
			tag_out <= tag_r_s[DB];
		end
	end

	always_ff @(posedge clk) begin
		root <= sat_r_s[DB] ? '1 : root_r_s[DB];
	end
endmodule
`default_nettype wire

// ===== src/point_segment_distance.sv =====
// Distance from a 3D point to a segment, or to the infinite line through it when
// clamp_to_segment is 0. Coordinates are signed with 12 fractional bits; distance is
// the truncated square root in the same scale, saturating at all ones. One query is
// taken every cycle (busy stays low) and each result appears on done for one cycle.
// At any COORD_WIDTH the result passes through the divider (one quotient bit a stage,
// 50 stages) and the square root (one root bit a stage, 25 stages). The receiver
// cannot stall, so results must be taken as they come.
`default_nettype none
module point_segment_distance #(
	parameter int COORD_WIDTH = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [COORD_WIDTH-1:0] point_x,
	input wire logic signed [COORD_WIDTH-1:0] point_y,
	input wire logic signed [COORD_WIDTH-1:0] point_z,
	input wire logic signed [COORD_WIDTH-1:0] seg_start_x,
	input wire logic signed [COORD_WIDTH-1:0] seg_start_y,
	input wire logic signed [COORD_WIDTH-1:0] seg_start_z,
	input wire logic signed [COORD_WIDTH-1:0] seg_end_x,
	input wire logic signed [COORD_WIDTH-1:0] seg_end_y,
	input wire logic signed [COORD_WIDTH-1:0] seg_end_z,
	output logic done,
	output logic [psd_pkg::DIST_BITS-1:0] distance,
	output logic [psd_pkg::PART_BITS-1:0] nearest_part,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [psd_pkg::CFG_ADDR_BITS-1:0] paddr,
	input wire logic [psd_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [psd_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic pready
);
	localparam int CW = COORD_WIDTH;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int SUMW = 2 * DW;
	localparam int DOTW = 2 * DW + 1;
	localparam int CRW = 2 * DW - 1;
	localparam int SPL = (CRW + 1) / 2;
	localparam int HIW = CRW - SPL;
	localparam int SQW = 2 * CRW;
	localparam int NUMW = SQW + 2;
	localparam int DENW = SUMW;

	localparam logic [1:0] SEL_CROSS = 2'd0;
	localparam logic [1:0] SEL_END = 2'd1;
	localparam logic [1:0] SEL_START = 2'd2;

	logic clamp_q;
	logic cfg_wr;
	logic in_go;

	assign busy = 1'b0;
	assign pready = 1'b1;
	assign in_go = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == psd_pkg::REG_CLAMP_TO_SEGMENT && paddr[1:0] == 2'd0)
		? psd_pkg::CFG_DATA_BITS'(clamp_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= 1'b1;
		end else if (cfg_wr && paddr[2] == psd_pkg::REG_CLAMP_TO_SEGMENT) begin
			clamp_q <= pwdata[0];
		end
	end

	// stage 1: differences
	logic v_s1, mode_s1;
	logic signed [DW-1:0] w_s1 [3];
	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] e_s1 [3];
	logic signed [DW-1:0] p_ext [3];
	logic signed [DW-1:0] s_ext [3];
	logic signed [DW-1:0] q_ext [3];

	assign p_ext[0] = $signed({point_x[CW-1], point_x});
	assign p_ext[1] = $signed({point_y[CW-1], point_y});
	assign p_ext[2] = $signed({point_z[CW-1], point_z});
	assign s_ext[0] = $signed({seg_start_x[CW-1], seg_start_x});
	assign s_ext[1] = $signed({seg_start_y[CW-1], seg_start_y});
	assign s_ext[2] = $signed({seg_start_z[CW-1], seg_start_z});
	assign q_ext[0] = $signed({seg_end_x[CW-1], seg_end_x});
	assign q_ext[1] = $signed({seg_end_y[CW-1], seg_end_y});
	assign q_ext[2] = $signed({seg_end_z[CW-1], seg_end_z});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_go;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= clamp_q;
		for (int i = 0; i < 3; i++) begin
			w_s1[i] <= p_ext[i] - s_ext[i];
			d_s1[i] <= q_ext[i] - s_ext[i];
			e_s1[i] <= p_ext[i] - q_ext[i];
		end
	end

	// stage 2: products
	logic v_s2, mode_s2;
	logic signed [PW-1:0] dd_p_s2 [3];
	logic signed [PW-1:0] ww_p_s2 [3];
	logic signed [PW-1:0] ee_p_s2 [3];
	logic signed [PW-1:0] wd_p_s2 [3];
	logic signed [PW-1:0] xa_s2 [3];
	logic signed [PW-1:0] xb_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		for (int i = 0; i < 3; i++) begin
			dd_p_s2[i] <= d_s1[i] * d_s1[i];
			ww_p_s2[i] <= w_s1[i] * w_s1[i];
			ee_p_s2[i] <= e_s1[i] * e_s1[i];
			wd_p_s2[i] <= w_s1[i] * d_s1[i];
		end
		xa_s2[0] <= w_s1[1] * d_s1[2];
		xb_s2[0] <= w_s1[2] * d_s1[1];
		xa_s2[1] <= w_s1[2] * d_s1[0];
		xb_s2[1] <= w_s1[0] * d_s1[2];
		xa_s2[2] <= w_s1[0] * d_s1[1];
		xb_s2[2] <= w_s1[1] * d_s1[0];
	end

	// stage 3: dot products and cross magnitudes
	logic v_s3, mode_s3;
	logic [SUMW-1:0] dd_s3, ww_s3, ee_s3;
	logic signed [DOTW-1:0] dot_s3;
	logic [CRW-1:0] cx_s3 [3];
	logic signed [PW:0] cdiff [3];

	for (genvar k = 0; k < 3; k++) begin : g_cross
		assign cdiff[k] = $signed({xa_s2[k][PW-1], xa_s2[k]}) - $signed({xb_s2[k][PW-1], xb_s2[k]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		dd_s3 <= $unsigned(dd_p_s2[0]) + $unsigned(dd_p_s2[1]) + $unsigned(dd_p_s2[2]);
		ww_s3 <= $unsigned(ww_p_s2[0]) + $unsigned(ww_p_s2[1]) + $unsigned(ww_p_s2[2]);
		ee_s3 <= $unsigned(ee_p_s2[0]) + $unsigned(ee_p_s2[1]) + $unsigned(ee_p_s2[2]);
		dot_s3 <= $signed({wd_p_s2[0][PW-1], wd_p_s2[0]})
			+ $signed({wd_p_s2[1][PW-1], wd_p_s2[1]})
			+ $signed({wd_p_s2[2][PW-1], wd_p_s2[2]});
		for (int i = 0; i < 3; i++) begin
			cx_s3[i] <= cdiff[i][PW] ? CRW'(-cdiff[i]) : CRW'(cdiff[i]);
		end
	end

	// stage 4: partial squares and region tests
	logic v_s4, mode_s4, ddz_s4, inr_s4, eele_s4;
	logic [SUMW-1:0] dd_s4, ww_s4, ee_s4;
	logic [2*SPL-1:0] ll_s4 [3];
	logic [SPL+HIW-1:0] lh_s4 [3];
	logic [2*HIW-1:0] hh_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		mode_s4 <= mode_s3;
		dd_s4 <= dd_s3;
		ww_s4 <= ww_s3;
		ee_s4 <= ee_s3;
		ddz_s4 <= (dd_s3 == '0);
		inr_s4 <= !dot_s3[DOTW-1] && (dot_s3[SUMW-1:0] <= dd_s3);
		eele_s4 <= (ee_s3 <= ww_s3);
		for (int i = 0; i < 3; i++) begin
			ll_s4[i] <= cx_s3[i][SPL-1:0] * cx_s3[i][SPL-1:0];
			lh_s4[i] <= cx_s3[i][SPL-1:0] * cx_s3[i][CRW-1:SPL];
			hh_s4[i] <= cx_s3[i][CRW-1:SPL] * cx_s3[i][CRW-1:SPL];
		end
	end

	// stage 5: cross squares and choice of operand
	logic v_s5;
	logic [1:0] sel_s5;
	logic [psd_pkg::PART_BITS-1:0] part_s5;
	logic [SUMW-1:0] dd_s5, ww_s5, ee_s5;
	logic [SQW-1:0] sq_s5 [3];
	logic [1:0] sel_n;
	logic [psd_pkg::PART_BITS-1:0] part_n;

	always_comb begin
		sel_n = SEL_CROSS;
		part_n = psd_pkg::PART_INTERIOR;
		if (mode_s4) begin
			if (ddz_s4) begin
				sel_n = SEL_END;
				part_n = psd_pkg::PART_END;
			end else if (!inr_s4) begin
				if (eele_s4) begin
					sel_n = SEL_END;
					part_n = psd_pkg::PART_END;
				end else begin
					sel_n = SEL_START;
					part_n = psd_pkg::PART_START;
				end
			end
		end else if (ddz_s4) begin
			sel_n = SEL_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sel_s5 <= sel_n;
		part_s5 <= part_n;
		dd_s5 <= dd_s4;
		ww_s5 <= ww_s4;
		ee_s5 <= ee_s4;
		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= (SQW'(hh_s4[i]) << (2 * SPL)) + (SQW'(lh_s4[i]) << (SPL + 1))
				+ SQW'(ll_s4[i]);
		end
	end

	// stage 6: numerator and denominator
	psd_pkg::psd_tag_t tag_s6;
	logic [NUMW-1:0] num_s6;
	logic [DENW-1:0] den_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s6 <= '0;
		end else begin
			tag_s6.valid <= v_s5;
			tag_s6.part <= part_s5;
		end
	end

	always_ff @(posedge clk) begin
		case (sel_s5)
			SEL_END: begin
				num_s6 <= NUMW'(ee_s5);
				den_s6 <= DENW'(1);
			end
			SEL_START: begin
				num_s6 <= NUMW'(ww_s5);
				den_s6 <= DENW'(1);
			end
			default: begin
				num_s6 <= NUMW'(sq_s5[0]) + NUMW'(sq_s5[1]) + NUMW'(sq_s5[2]);
				den_s6 <= dd_s5;
			end
		endcase
	end

	psd_pkg::psd_tag_t tag_o;

	psd_ratio_root #(
		.NUMW(NUMW),
		.DENW(DENW)
	) u_root (
		.clk(clk),
		.arst_n(arst_n),
		.tag_in(tag_s6),
		.num(num_s6),
		.den(den_s6),
		.tag_out(tag_o),
		.root(distance)
	);

	assign done = tag_o.valid;
	assign nearest_part = tag_o.part;
endmodule
`default_nettype wire

// ===== test/point_segment_distance_tb.sv =====
`default_nettype none
class psd_scoreboard;
	typedef struct {
		logic [24:0] dist_val;
		logic [1:0] part;
	} dist_beat_t;

	dist_beat_t pending_q[$];
	int mismatches;
	int checked;
	bit clamp;

	function new();
		mismatches = 0;
		checked = 0;
		clamp = 1'b1;
	endfunction

	// largest r below 2^25 with r*r*den <= num
	function automatic logic [24:0] ratio_root(logic [159:0] num, logic [159:0] den);
		logic [24:0] r;
		logic [24:0] t;
		logic [159:0] prod;
		r = '0;
		for (int b = 24; b >= 0; b--) begin
			t = r | (25'd1 << b);
			prod = 160'(t) * 160'(t) * den;
			if (prod <= num)
				r = t;
		end
		return r;
	endfunction

	function void note_query(logic signed [23:0] c[9]);
		logic signed [63:0] w[3];
		logic signed [63:0] d[3];
		logic signed [63:0] e[3];
		logic signed [159:0] dd, ww, ee, wd, cx, cy, cz, c2;
		dist_beat_t x;
		for (int i = 0; i < 3; i++) begin
			w[i] = 64'(c[i]) - 64'(c[3+i]);
			d[i] = 64'(c[6+i]) - 64'(c[3+i]);
			e[i] = 64'(c[i]) - 64'(c[6+i]);
		end
		dd = 160'(d[0]) * d[0] + 160'(d[1]) * d[1] + 160'(d[2]) * d[2];
		ww = 160'(w[0]) * w[0] + 160'(w[1]) * w[1] + 160'(w[2]) * w[2];
		ee = 160'(e[0]) * e[0] + 160'(e[1]) * e[1] + 160'(e[2]) * e[2];
		wd = 160'(w[0]) * d[0] + 160'(w[1]) * d[1] + 160'(w[2]) * d[2];
		cx = 160'(w[1]) * d[2] - 160'(w[2]) * d[1];
		cy = 160'(w[2]) * d[0] - 160'(w[0]) * d[2];
		cz = 160'(w[0]) * d[1] - 160'(w[1]) * d[0];
		c2 = cx * cx + cy * cy + cz * cz;
		x.part = psd_pkg::PART_INTERIOR;
		if (clamp) begin
			if (dd == 0) begin
				x.dist_val = ratio_root(ee, 1);
				x.part = psd_pkg::PART_END;
			end else if (wd >= 0 && wd <= dd) begin
				x.dist_val = ratio_root(c2, dd);
			end else if (ee <= ww) begin
				x.dist_val = ratio_root(ee, 1);
				x.part = psd_pkg::PART_END;
			end else begin
				x.dist_val = ratio_root(ww, 1);
				x.part = psd_pkg::PART_START;
			end
		end else if (dd == 0) begin
			x.dist_val = ratio_root(ww, 1);
		end else begin
			x.dist_val = ratio_root(c2, dd);
		end
		pending_q.push_back(x);
	endfunction

	function void check_result(logic [24:0] got_dist, logic [1:0] part);
		dist_beat_t x;
		checked++;
		if (pending_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat: distance %0d part %0d", got_dist, part);
			return;
		end
		x = pending_q.pop_front();
		if (got_dist !== x.dist_val || part !== x.part) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected distance %0d part %0d, got %0d part %0d",
					x.dist_val, x.part, got_dist, part);
		end
	endfunction
endclass

module point_segment_distance_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 83;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [23:0] crd[9];
	logic done;
	logic [24:0] distance;
	logic [1:0] nearest_part;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [psd_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
	logic [psd_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
	logic [psd_pkg::CFG_DATA_BITS-1:0] prdata;
	logic pready;

	psd_scoreboard sb;
	int sent;

	initial
		for (int i = 0; i < 9; i++)
			crd[i] = '0;

	always #1 clk = ~clk;

	point_segment_distance u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x(crd[0]), .point_y(crd[1]), .point_z(crd[2]),
		.seg_start_x(crd[3]), .seg_start_y(crd[4]), .seg_start_z(crd[5]),
		.seg_end_x(crd[6]), .seg_end_y(crd[7]), .seg_end_z(crd[8]),
		.done(done), .distance(distance), .nearest_part(nearest_part),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always @(posedge clk)
		if (arst_n && done)
			sb.check_result(distance, nearest_part);

	task automatic write_clamp(bit value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= psd_pkg::CFG_ADDR_BITS'(psd_pkg::REG_CLAMP_TO_SEGMENT) << 2;
		pwdata <= {31'h5a5a5a5a, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.clamp = value;
	endtask

	// drive one query; start stays high if the next beat follows at once
	task automatic send_query(logic signed [23:0] c[9], bit keep);
		for (int i = 0; i < 9; i++)
			crd[i] <= c[i];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_query(c);
		sent++;
		if (!keep)
			start <= 1'b0;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (sb.pending_q.size() != 0 && guard < 10 * LATENCY) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_coord(int mode);
		case (mode)
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 8191)) - 24'sd4096;
			2: return ($urandom_range(0, 1)) ? 24'sh7fffff : 24'sh800000;
			default: return 24'($urandom_range(0, 65535)) - 24'sd32768;
		endcase
	endfunction

	task automatic random_phase(int count);
		logic signed [23:0] c[9];
		int burst;
		int kind;
		int mode;
		for (int n = 0; n < count; n++) begin
			if (burst <= 0) begin
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
			end
			mode = $urandom_range(0, 3);
			for (int i = 0; i < 9; i++)
				c[i] = rand_coord(mode);
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				for (int i = 0; i < 3; i++)
					c[6+i] = c[3+i];
			end else if (kind == 1) begin
				for (int i = 0; i < 3; i++)
					c[i] = c[3+i];
			end else if (kind == 2) begin
				// midpoint perpendicular: endpoint tie
				c[0] = c[3] + 24'sd100;
				c[6] = c[3] + 24'sd200;
				c[1] = c[4] + 24'sd300;
				c[7] = c[4];
				c[2] = c[5];
				c[8] = c[5];
			end else if (kind == 3) begin
				for (int i = 0; i < 3; i++)
					c[i] = c[6+i];
			end
			burst--;
			send_query(c, burst > 0 && n < count - 1);
		end
	endtask

	task automatic directed_phase();
		logic signed [23:0] c[9];
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 9; i++)
				c[i] = '0;
			case (k)
				0: ;
				1: for (int i = 0; i < 9; i++) c[i] = (i < 3) ? 24'sh7fffff : 24'sh800000;
				2: for (int i = 0; i < 9; i++) c[i] = (i < 6) ? 24'sh800000 : 24'sh7fffff;
				3: begin c[0] = 24'sd4096; c[6] = 24'sd8192; end
				4: begin c[0] = -24'sd4096; c[1] = 24'sd4096; c[6] = 24'sd8192; end
				5: begin c[0] = 24'sd12288; c[1] = 24'sd4096; c[6] = 24'sd8192; end
				6: begin c[0] = 24'sd4096; c[1] = 24'sd4096; c[6] = 24'sd8192; end
				7: begin c[0] = 24'sd8192; c[1] = 24'sd4096; c[6] = 24'sd8192; end
				8: begin c[1] = 24'sd4096; c[6] = 24'sd8192; end
				9: begin c[0] = 24'sh7fffff; c[1] = 24'sh7fffff; c[2] = 24'sh7fffff;
					c[3] = 24'sh800000; c[4] = 24'sh800000; c[5] = 24'sh800000;
					c[6] = 24'sh800000; c[7] = 24'sh800000; c[8] = 24'sh800000; end
				10: for (int i = 0; i < 9; i++) c[i] = 24'(-1);
				default: for (int i = 0; i < 9; i++) c[i] = 24'($urandom);
			endcase
			send_query(c, k < 11);
		end
	endtask

	initial begin
		sb = new();
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_phase();
		drain();
		write_clamp(1'b0);
		directed_phase();
		random_phase(350);
		drain();
		write_clamp(1'b1);
		random_phase(350);
		drain();
		write_clamp(1'b0);
		random_phase(300);
		drain();
		write_clamp(1'b1);
		random_phase(350);
		drain();
		$display("covered %0d queries, %0d result beats, segment and line modes",
			sent, sb.checked);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches,
				sb.pending_q.size());
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout");
		$display("status: fail");
		$finish;
	end
endmodule

// ===== files.f =====
src/psd_pkg.sv
src/psd_ratio_root.sv
src/point_segment_distance.sv
test/point_segment_distance_tb.sv
